// ===== rtl/core/lfmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfmtc_pkg
// Shared types and codes for the stack / queue / priority-queue trace checker.
// ----------------------------------------------------------------------------
package lfmtc_pkg;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned VerdictW = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_NOT_SURE   = 3'd1,
    VERDICT_STACK      = 3'd2,
    VERDICT_QUEUE      = 3'd3,
    VERDICT_PRIO       = 3'd4
  } verdict_e;

  // consistency flag bits
  localparam int unsigned FlagStack = 0;
  localparam int unsigned FlagQueue = 1;
  localparam int unsigned FlagHeap  = 2;

  function automatic logic [VerdictW-1:0] verdict_of(input logic [2:0] f);
    logic [VerdictW-1:0] v;
    unique case (f)
      3'b000:  v = VERDICT_IMPOSSIBLE;
      3'b001:  v = VERDICT_STACK;
      3'b010:  v = VERDICT_QUEUE;
      3'b100:  v = VERDICT_PRIO;
      default: v = VERDICT_NOT_SURE;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lfmtc_req_if.sv =====
// ----------------------------------------------------------------------------
// lfmtc_req_if
// Trace item channel: request code and value.
// ----------------------------------------------------------------------------
interface lfmtc_req_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic [lfmtc_pkg::ReqW-1:0] req_type;
  logic [DATA_WIDTH-1:0]      value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

// ===== rtl/core/lfmtc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfmtc_rsp_if
// Result channel: verdict and sticky overflow.
// ----------------------------------------------------------------------------
interface lfmtc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lfmtc_pkg::VerdictW-1:0] verdict;
  logic                           overflow;

  modport source (output valid, verdict, overflow, input ready);
  modport sink   (input valid, verdict, overflow, output ready);
endinterface

// ===== rtl/core/lifo_fifo_maxheap_trace_classifier.sv =====
// ----------------------------------------------------------------------------
// lifo_fifo_maxheap_trace_classifier
// Checks a push/pop trace against stack, FIFO and max-heap disciplines.
// ----------------------------------------------------------------------------
//  channel  | dir | payload             | transfer
//  req_i    | in  | req_type, value     | valid & ready
//  rsp_o    | out | verdict, overflow   | valid & ready
//
// From request transfer to result valid: clear and ignored codes answer
// directly; dropped push and pop from empty pass the done state; push
// sifts up (read parent, compare and move per level); pop reads the top
// and the last item, then sifts down (read left, read right, compare and
// move per level).
// Reset clears counts and overflow and sets all flags; stores need no clearing.
// The result waits in an output register; a new item is taken only after
// the previous result has been transferred.
module lifo_fifo_maxheap_trace_classifier #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  lfmtc_req_if.sink   req_i,
  lfmtc_rsp_if.source rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = CW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(DEPTH - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUSHR = 4'd1; // place at root or read parent
  localparam logic [3:0] S_PUSHC = 4'd2; // compare parent with value
  localparam logic [3:0] S_POPT  = 4'd3; // read top
  localparam logic [3:0] S_POPV  = 4'd4; // check observed value, read last
  localparam logic [3:0] S_POPG  = 4'd5; // take last
  localparam logic [3:0] S_POPL  = 4'd6; // read left child or finish
  localparam logic [3:0] S_POPR  = 4'd7; // take left, read right child
  localparam logic [3:0] S_POPC  = 4'd8; // compare and move
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_q, state_d;

  logic [DATA_WIDTH-1:0] lifo_mem [DEPTH];
  logic [DATA_WIDTH-1:0] fifo_mem [DEPTH];
  logic [DATA_WIDTH-1:0] heap_mem [DEPTH];

  logic [CW-1:0] count_q;
  logic [AW-1:0] head_q, tail_q;
  logic [2:0]    flags_q;
  logic          ovf_q;
  logic          rsp_valid_q;
  logic [lfmtc_pkg::VerdictW-1:0] verdict_q;

  logic [DATA_WIDTH-1:0] val_q, last_q, lchild_q, rd_q;
  logic [CW-1:0]         idx_q;   // current hole position
  logic [CW-1:0]         n_q;     // heap size during the sift
  logic [DATA_WIDTH-1:0] lifo_rd_q, fifo_rd_q;

  logic accept;
  logic is_push, is_pop, has_room, is_empty;
  logic push_ok, pop_ok, answer_now;
  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign is_push     = (req_i.req_type == lfmtc_pkg::REQ_PUSH);
  assign is_pop      = (req_i.req_type == lfmtc_pkg::REQ_POP);
  assign has_room    = (count_q < DepthC);
  assign is_empty    = (count_q == '0);
  assign push_ok     = accept && is_push && has_room;
  assign pop_ok      = accept && is_pop && !is_empty;
  // clear and ignored codes load the result register on transfer, with no sequencer pass
  assign answer_now  = accept && !is_push && !is_pop;

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.verdict  = verdict_q;
  assign rsp_o.overflow = ovf_q;

  // heap index arithmetic
  logic [CW-1:0] parent;
  logic [XW-1:0] lc, rc, n_x;
  assign parent = (idx_q - CW'(1)) >> 1;
  assign lc     = {idx_q, 1'b1};
  assign rc     = lc + XW'(1);
  assign n_x    = {1'b0, n_q};

  // larger child; the left one wins a tie
  logic                  right_wins;
  logic [DATA_WIDTH-1:0] best_v;
  logic [CW-1:0]         best_i;
  assign right_wins = (rc < n_x) && (rd_q > lchild_q);
  assign best_v     = right_wins ? rd_q : lchild_q;
  assign best_i     = right_wins ? rc[CW-1:0] : lc[CW-1:0];

  // heap memory port
  logic                  hwe;
  logic [AW-1:0]         hwa, hra;
  logic [DATA_WIDTH-1:0] hwd;
  logic [AW-1:0]         lifo_ra;
  assign lifo_ra = AW'(count_q - CW'(1));

  // sequencer and heap port control
  always_comb begin
    state_d = state_q;
    hwe = 1'b0;
    hwa = idx_q[AW-1:0];
    hwd = val_q;
    hra = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (is_push && has_room) begin
            state_d = S_PUSHR;
          end else if (is_pop && !is_empty) begin
            state_d = S_POPT;
          end else if (is_push || is_pop) begin
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PUSHR: begin
        if (idx_q == '0) begin
          hwe = 1'b1;
          state_d = S_DONE;
        end else begin
          hra = parent[AW-1:0];
          state_d = S_PUSHC;
        end
      end
      S_PUSHC: begin
        // rd_q holds the parent value
        hwe = 1'b1;
        if (rd_q >= val_q) begin
          state_d = S_DONE;
        end else begin
          hwd = rd_q;
          state_d = S_PUSHR;
        end
      end
      S_POPT: begin
        hra = '0;
        state_d = S_POPV;
      end
      S_POPV: begin
        hra = n_q[AW-1:0];
        state_d = S_POPG;
      end
      S_POPG: begin
        state_d = S_POPL;
      end
      S_POPL: begin
        if (lc >= n_x) begin
          hwe = (n_q != '0);
          hwd = last_q;
          state_d = S_DONE;
        end else begin
          hra = lc[AW-1:0];
          state_d = S_POPR;
        end
      end
      S_POPR: begin
        hra = rc[AW-1:0];
        state_d = S_POPC;
      end
      S_POPC: begin
        hwe = 1'b1;
        if (best_v <= last_q) begin
          hwd = last_q;
          state_d = S_DONE;
        end else begin
          hwd = best_v;
          state_d = S_POPL;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // heap memory
  always_ff @(posedge clk_i) begin
    if (hwe) heap_mem[hwa] <= hwd;
    rd_q <= heap_mem[hra];
  end

  // stack and ring memories, read on transfer
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      lifo_mem[count_q[AW-1:0]] <= req_i.value;
      fifo_mem[tail_q]          <= req_i.value;
    end
    if (accept) begin
      lifo_rd_q <= lifo_mem[lifo_ra];
      fifo_rd_q <= fifo_mem[head_q];
    end
  end

  // sift datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) val_q <= req_i.value;
    if (state_q == S_POPG) last_q <= rd_q;
    if (state_q == S_POPR) lchild_q <= rd_q;
    if (pop_ok) n_q <= count_q - CW'(1);
    if (push_ok) begin
      idx_q <= count_q;
    end else if (pop_ok) begin
      idx_q <= '0;
    end else if (state_q == S_PUSHC && rd_q < val_q) begin
      idx_q <= parent;
    end else if (state_q == S_POPC && best_v > last_q) begin
      idx_q <= best_i;
    end
  end

  // counts, flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      flags_q     <= '1;
      ovf_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      verdict_q   <= lfmtc_pkg::VERDICT_NOT_SURE;
    end else begin
      state_q <= state_d;
      if (push_ok) begin
        count_q <= count_q + CW'(1);
        tail_q  <= (tail_q == LastA) ? '0 : tail_q + AW'(1);
      end else if (pop_ok) begin
        count_q <= count_q - CW'(1);
        head_q  <= (head_q == LastA) ? '0 : head_q + AW'(1);
      end else if (answer_now && req_i.req_type == lfmtc_pkg::REQ_CLEAR) begin
        count_q <= '0;
        head_q  <= '0;
        tail_q  <= '0;
      end

      if (accept && is_push && !has_room) ovf_q <= 1'b1;

      // all three structures are empty together
      if (accept && is_pop && is_empty) begin
        flags_q <= '0;
      end else if (answer_now && req_i.req_type == lfmtc_pkg::REQ_CLEAR) begin
        flags_q <= '1;
      end else if (state_q == S_POPV) begin
        // rd_q holds the heap top
        if (lifo_rd_q != val_q) flags_q[lfmtc_pkg::FlagStack] <= 1'b0;
        if (fifo_rd_q != val_q) flags_q[lfmtc_pkg::FlagQueue] <= 1'b0;
        if (rd_q != val_q)      flags_q[lfmtc_pkg::FlagHeap]  <= 1'b0;
      end

      if (answer_now || state_q == S_DONE) begin
        rsp_valid_q <= 1'b1;
        verdict_q   <= lfmtc_pkg::verdict_of(flags_q);
      end else if (rsp_o.valid && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // a finished result is shown until transferred
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("result dropped");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(rsp_o.verdict) && $stable(rsp_o.overflow))
    else $error("result changed while waiting");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !req_i.ready)
    else $error("ready while busy");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("count beyond depth");

endmodule
